[rtl/fqrm_pkg.sv]
`timescale 1ns / 1ps

package fqrm_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    ACT_ENQ   = 2'd0,
    ACT_DEQ   = 2'd1,
    ACT_RMMAX = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  // ring pointer advance with wrap at the last slot
  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    if (p == ADDR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

endpackage

[rtl/fifo_queue_remove_max.sv]
`timescale 1ns / 1ps

// result: registered in S_DONE after the accepting edge; a dequeue that leaves the queue
// nonempty passes through S_DEQ first, and remove-max on count entries makes two sweeps
// throughput: one transaction at a time; the slot memory's single read port sets the sweep
// rate of one entry per cycle, and a stalled output holds the next result
// reset: head, tail, held entry count and handshake state clear; slot memory is not cleared

module fifo_queue_remove_max (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          action,
  input  logic signed [fqrm_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                ok,
  output logic signed [fqrm_pkg::DATA_W-1:0]  out_value,
  output logic                                front_valid,
  output logic signed [fqrm_pkg::DATA_W-1:0]  front_value,
  output logic [fqrm_pkg::COUNT_W-1:0]        count
);
  import fqrm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN,
    S_PACK,
    S_DONE
  } state_t;

  state_t state;

  logic signed [DATA_W-1:0] slots [DEPTH];
  logic signed [DATA_W-1:0] rd_data;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_wa;
  logic signed [DATA_W-1:0] mem_wd;

  logic [ADDR_W-1:0]        head;
  logic [ADDR_W-1:0]        tail;
  logic [CNT_W-1:0]         held;
  logic signed [DATA_W-1:0] front;

  logic [ADDR_W-1:0]        rd_ptr;
  logic [ADDR_W-1:0]        wr_ptr;
  logic [CNT_W-1:0]         issued;
  logic [CNT_W-1:0]         kept;
  logic                     pend;
  logic signed [DATA_W-1:0] best;

  logic                     res_ok;
  logic signed [DATA_W-1:0] res_out;

  logic                     accept;
  logic                     not_full;
  logic                     issue;
  logic                     sweep_done;
  logic                     keep_entry;
  logic                     out_free;
  logic [CNT_W-1:0]         held_dec;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign not_full   = (held < CNT_W'(DEPTH));
  assign issue      = (issued < held);
  assign sweep_done = !issue && !pend;
  assign keep_entry = pend && (rd_data != best);
  assign out_free   = !out_valid || out_ready;
  assign held_dec   = held - 1'b1;

  // slot memory access
  always_comb begin
    rd_addr = rd_ptr;
    mem_we  = 1'b0;
    mem_wa  = tail;
    mem_wd  = in_value;
    if (state == S_IDLE) begin
      rd_addr = ptr_inc(head);
      mem_we  = accept && (action_t'(action) == ACT_ENQ) && not_full;
    end else if (state == S_PACK) begin
      mem_we = keep_entry;
      mem_wa = wr_ptr;
      mem_wd = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slots[mem_wa] <= mem_wd;
    end
    rd_data <= slots[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      held      <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action_t'(action))
              ACT_ENQ: begin
                res_ok  <= not_full;
                res_out <= '0;
                state   <= S_DONE;
                if (not_full) begin
                  tail <= ptr_inc(tail);
                  held <= held + 1'b1;
                  if (held == '0) begin
                    front <= in_value;
                  end
                end
              end
              ACT_DEQ: begin
                res_ok  <= (held != '0);
                res_out <= (held != '0) ? front : '0;
                if (held != '0) begin
                  held <= held_dec;
                  if (held_dec == '0) begin
                    head  <= '0;
                    tail  <= '0;
                    state <= S_DONE;
                  end else begin
                    head  <= ptr_inc(head);
                    state <= S_DEQ;
                  end
                end else begin
                  state <= S_DONE;
                end
              end
              ACT_RMMAX: begin
                res_ok  <= 1'b0;
                res_out <= '0;
                if (held != '0) begin
                  rd_ptr <= head;
                  issued <= '0;
                  pend   <= 1'b0;
                  best   <= {1'b1, {(DATA_W-1){1'b0}}};
                  state  <= S_SCAN;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                head    <= '0;
                tail    <= '0;
                held    <= '0;
                res_ok  <= 1'b1;
                res_out <= '0;
                state   <= S_DONE;
              end
            endcase
          end
        end
        S_DEQ: begin
          // new head entry was read at the accept edge
          front <= rd_data;
          state <= S_DONE;
        end
        S_SCAN: begin
          if (pend && (rd_data > best)) begin
            best <= rd_data;
          end
          if (issue) begin
            rd_ptr <= ptr_inc(rd_ptr);
            issued <= issued + 1'b1;
          end
          pend <= issue;
          if (sweep_done) begin
            rd_ptr <= head;
            wr_ptr <= head;
            issued <= '0;
            kept   <= '0;
            state  <= S_PACK;
          end
        end
        S_PACK: begin
          // writes trail reads, so a write never hits the slot being read
          if (keep_entry) begin
            wr_ptr <= ptr_inc(wr_ptr);
            kept   <= kept + 1'b1;
            if (kept == '0) begin
              front <= rd_data;
            end
          end
          if (issue) begin
            rd_ptr <= ptr_inc(rd_ptr);
            issued <= issued + 1'b1;
          end
          pend <= issue;
          if (sweep_done) begin
            held   <= kept;
            res_ok <= 1'b1;
            state  <= S_DONE;
            if (kept == '0) begin
              head <= '0;
              tail <= '0;
            end else begin
              tail <= wr_ptr;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            ok          <= res_ok;
            out_value   <= res_out;
            front_valid <= (held != '0);
            front_value <= (held != '0) ? front : '0;
            count       <= COUNT_W'(held);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
